// File: sv/eli_pkg.sv
package eli_pkg;

    // fixed widths of times and weights
    localparam int TimeWidth   = 32;
    localparam int WeightWidth = 32;
    localparam int DiffWidth   = TimeWidth + 1;
    localparam int ProdWidth   = 2 * TimeWidth;
    localparam int NumWeights  = 7;
    localparam int AddrWidth   = 4;

    // error codes
    typedef logic [1:0] t_err;
    localparam t_err ERR_OK    = 2'd0;
    localparam t_err ERR_EQUAL = 2'd1;
    localparam t_err ERR_SPAN  = 2'd2;

    // register indexes
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_TIME_ONE   = 2'd0;
    localparam t_reg_idx REG_TIME_TWO   = 2'd1;
    localparam t_reg_idx REG_TIME_THREE = 2'd2;
    localparam t_reg_idx REG_TARGET     = 2'd3;

    typedef struct packed {
        logic signed [TimeWidth-1:0] time_one;
        logic signed [TimeWidth-1:0] time_two;
        logic signed [TimeWidth-1:0] time_three;
        logic signed [TimeWidth-1:0] target_time;
    } t_times;

    typedef struct packed {
        logic [2:0][WeightWidth-1:0] quad;
        logic [3:0][WeightWidth-1:0] lin;
        logic                        ready;
    } t_weights;

endpackage

// File: sv/eli_in_if.sv
interface eli_in_if #(
    parameter int SampleWidth = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SampleWidth-1:0] sample_one;
    logic signed [SampleWidth-1:0] sample_two;
    logic signed [SampleWidth-1:0] sample_three;
    logic                          last_point;

    modport source (output valid, sample_one, sample_two, sample_three, last_point,
                    input ready);
    modport sink   (input valid, sample_one, sample_two, sample_three, last_point,
                    output ready);
endinterface

// File: sv/eli_out_if.sv
interface eli_out_if #(
    parameter int SampleWidth = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SampleWidth-1:0] value;
    logic                          used_linear;
    logic [1:0]                    error_code;
    logic                          last_result;

    modport source (output valid, value, used_linear, error_code, last_result,
                    input ready);
    modport sink   (input valid, value, used_linear, error_code, last_result,
                    output ready);
endinterface

// File: sv/eli_apb_regs.sv
module eli_apb_regs
    import eli_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output t_times               o_times,
    output logic                 o_wr
);
    t_times   r_times;
    t_reg_idx idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign o_wr   = psel && penable && pwrite;
    assign o_times = r_times;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_times.time_one    <= 32'sd0;
            r_times.time_two    <= 32'sd65536;
            r_times.time_three  <= 32'sd131072;
            r_times.target_time <= 32'sd0;
        end else if (o_wr) begin
            unique case (idx)
                REG_TIME_ONE:   r_times.time_one    <= pwdata;
                REG_TIME_TWO:   r_times.time_two    <= pwdata;
                REG_TIME_THREE: r_times.time_three  <= pwdata;
                REG_TARGET:     r_times.target_time <= pwdata;
                default:        r_times.target_time <= pwdata;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (idx)
            REG_TIME_ONE:   prdata = r_times.time_one;
            REG_TIME_TWO:   prdata = r_times.time_two;
            REG_TIME_THREE: prdata = r_times.time_three;
            REG_TARGET:     prdata = r_times.target_time;
            default:        prdata = r_times.target_time;
        endcase
    end
endmodule

// File: sv/eli_weight_unit.sv
module eli_weight_unit
    import eli_pkg::*;
#(
    parameter int WEIGHT_FRACTION_BITS = 28
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_times   i_times,
    input  logic     i_wr,
    output t_weights o_weights
);
    localparam int DivSteps = ProdWidth + WEIGHT_FRACTION_BITS;
    localparam int CntWidth = $clog2(DivSteps);
    localparam int QuoWidth = WeightWidth + 2;

    typedef enum logic [4:0] {
        S_MUL_N = 5'b00001,
        S_MUL_D = 5'b00010,
        S_DIV   = 5'b00100,
        S_STORE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    function automatic logic [TimeWidth-1:0] mag(input logic signed [DiffWidth-1:0] d);
        logic signed [DiffWidth-1:0] a;
        a = (d < 0) ? -d : d;
        return a[TimeWidth-1:0];
    endfunction

    t_state                       r_state;
    logic [2:0]                   r_idx;
    logic [CntWidth-1:0]          r_cnt;
    logic [ProdWidth-1:0]         r_num, r_den, r_sh, r_rem;
    logic [QuoWidth-1:0]          r_quo;
    logic                         r_big, r_neg, r_ready;
    logic [WeightWidth-1:0]       r_w [NumWeights];

    logic signed [DiffWidth-1:0]  t1, t2, t3, t;
    logic signed [DiffWidth-1:0]  dt1, dt2, dt3, d12, d13, d23;
    logic signed [DiffWidth-1:0]  na, nb, da, db;
    logic [TimeWidth-1:0]         mul_a, mul_b;
    logic [ProdWidth-1:0]         mul_p;
    logic [ProdWidth:0]           r2, diff;
    logic                         qb, rnd, sat;
    logic [QuoWidth:0]            qr, lim, qmag;
    logic [WeightWidth-1:0]       w;

    // time differences
    assign t1  = DiffWidth'(i_times.time_one);
    assign t2  = DiffWidth'(i_times.time_two);
    assign t3  = DiffWidth'(i_times.time_three);
    assign t   = DiffWidth'(i_times.target_time);
    assign dt1 = t - t1;
    assign dt2 = t - t2;
    assign dt3 = t - t3;
    assign d12 = t1 - t2;
    assign d13 = t1 - t3;
    assign d23 = t2 - t3;

    // operand select per weight
    always_comb begin
        unique case (r_idx)
            3'd0:    begin na = dt2; nb = dt3;          da = d12;  db = d13;  end
            3'd1:    begin na = dt1; nb = dt3;          da = -d12; db = d23;  end
            3'd2:    begin na = dt1; nb = dt2;          da = -d13; db = -d23; end
            3'd3:    begin na = dt2; nb = DiffWidth'(1); da = d12;  db = DiffWidth'(1); end
            3'd4:    begin na = dt1; nb = DiffWidth'(1); da = -d12; db = DiffWidth'(1); end
            3'd5:    begin na = dt3; nb = DiffWidth'(1); da = d23;  db = DiffWidth'(1); end
            default: begin na = dt2; nb = DiffWidth'(1); da = -d23; db = DiffWidth'(1); end
        endcase
    end

    // shared multiplier for numerator and denominator
    assign mul_a = (r_state == S_MUL_N) ? mag(na) : mag(da);
    assign mul_b = (r_state == S_MUL_N) ? mag(nb) : mag(db);
    assign mul_p = mul_a * mul_b;

    // restoring division step
    assign r2   = {r_rem, r_sh[ProdWidth-1]};
    assign diff = r2 - {1'b0, r_den};
    assign qb   = (r2 >= {1'b0, r_den});

    // rounding and saturation of the quotient
    assign rnd  = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign qr   = {1'b0, r_quo} + (QuoWidth+1)'(rnd);
    assign lim  = r_neg ? (QuoWidth+1)'(33'h080000000) : (QuoWidth+1)'(33'h07fffffff);
    assign sat  = r_big || (qr > lim);
    assign qmag = sat ? lim : qr;
    assign w    = (r_den == '0) ? '0
                : (r_neg ? (-qmag[WeightWidth-1:0]) : qmag[WeightWidth-1:0]);

    // weight sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr) begin
            r_state <= S_MUL_N;
            r_idx   <= 3'd0;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                S_MUL_N: r_state <= S_MUL_D;
                S_MUL_D: r_state <= S_DIV;
                S_DIV: begin
                    if (r_cnt == CntWidth'(DivSteps - 1)) r_state <= S_STORE;
                end
                S_STORE: begin
                    if (r_idx == 3'(NumWeights - 1)) begin
                        r_state <= S_DONE;
                        r_ready <= 1'b1;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_MUL_N;
                    end
                end
                S_DONE:  r_state <= S_DONE;
                default: r_state <= S_MUL_N;
            endcase
        end
    end

    // datapath of the divider
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL_N: begin
                r_num <= mul_p;
                r_neg <= ((na < 0) ^ (nb < 0)) ^ ((da < 0) ^ (db < 0));
            end
            S_MUL_D: begin
                r_den <= mul_p;
                r_sh  <= r_num;
                r_rem <= '0;
                r_quo <= '0;
                r_big <= 1'b0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_sh  <= {r_sh[ProdWidth-2:0], 1'b0};
                r_rem <= qb ? diff[ProdWidth-1:0] : r2[ProdWidth-1:0];
                r_big <= r_big | r_quo[QuoWidth-1];
                r_quo <= {r_quo[QuoWidth-2:0], qb};
                r_cnt <= r_cnt + CntWidth'(1);
            end
            S_STORE: r_w[r_idx] <= w;
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_weights.quad  = {r_w[2], r_w[1], r_w[0]};
    assign o_weights.lin   = {r_w[6], r_w[5], r_w[4], r_w[3]};
    assign o_weights.ready = r_ready;
endmodule

// File: sv/eli_blend_pipe.sv
module eli_blend_pipe
    import eli_pkg::*;
#(
    parameter int SAMPLE_WIDTH         = 32,
    parameter int WEIGHT_FRACTION_BITS = 28
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_times   i_times,
    input  t_weights i_weights,
    eli_in_if.sink   i_item,
    eli_out_if.source o_result
);
    localparam int SW        = SAMPLE_WIDTH;
    localparam int PW        = SW + WeightWidth;
    localparam int SumWidth  = (PW + 2 > WEIGHT_FRACTION_BITS + 2) ? PW + 2
                                                                   : WEIGHT_FRACTION_BITS + 2;
    localparam logic signed [SumWidth-1:0] Half = SumWidth'(1) << (WEIGHT_FRACTION_BITS - 1);
    localparam logic signed [SW-1:0] SMax = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMin = {1'b1, {(SW-1){1'b0}}};

    function automatic logic signed [SW-1:0] finish(input logic signed [SumWidth-1:0] s);
        logic signed [SumWidth-1:0] sh;
        sh = s >>> WEIGHT_FRACTION_BITS;
        if (sh > SumWidth'(SMax))      return SMax;
        else if (sh < SumWidth'(SMin)) return SMin;
        else                           return sh[SW-1:0];
    endfunction

    logic en1, en2, en3, acc;

    // stage 1: products, sample range, error
    logic                   r1_valid, r1_last;
    logic signed [PW-1:0]   r1_p0, r1_p1, r1_p2, r1_l0, r1_l1;
    logic signed [SW-1:0]   r1_min, r1_max;
    t_err                   r1_err;
    // stage 2: sums
    logic                   r2_valid, r2_last;
    logic signed [SumWidth-1:0] r2_qs, r2_ls;
    logic signed [SW-1:0]   r2_min, r2_max;
    t_err                   r2_err;
    // stage 3: output register
    logic                   r3_valid, r3_last, r3_lin;
    logic signed [SW-1:0]   r3_value;
    t_err                   r3_err;

    logic signed [SW-1:0]   s1, s2, s3, smin, smax, la, lb, qd, ld;
    logic signed [WeightWidth-1:0] wa, wb;
    logic signed [TimeWidth-1:0]   t1, t2, t3, t;
    logic                   first, lin;
    t_err                   err;

    assign en3 = !r3_valid || o_result.ready;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign i_item.ready = i_weights.ready && en1;
    assign acc = i_item.valid && i_item.ready;

    assign s1 = i_item.sample_one;
    assign s2 = i_item.sample_two;
    assign s3 = i_item.sample_three;
    assign t1 = i_times.time_one;
    assign t2 = i_times.time_two;
    assign t3 = i_times.time_three;
    assign t  = i_times.target_time;

    // error code and pair selection from the level times
    always_comb begin
        if (t1 == t2 || t1 == t3 || t2 == t3)
            err = ERR_EQUAL;
        else if ((t < t1 && t < t2 && t < t3) || (t > t1 && t > t2 && t > t3))
            err = ERR_SPAN;
        else
            err = ERR_OK;
        first = (t1 < t2) ? (t >= t1 && t <= t2) : (t >= t2 && t <= t1);
    end

    // range of the three samples
    always_comb begin
        smin = s1;
        smax = s1;
        if (s2 < smin) smin = s2;
        if (s3 < smin) smin = s3;
        if (s2 > smax) smax = s2;
        if (s3 > smax) smax = s3;
    end

    // linear pair operands
    assign la = first ? s1 : s2;
    assign lb = first ? s2 : s3;
    assign wa = first ? i_weights.lin[0] : i_weights.lin[2];
    assign wb = first ? i_weights.lin[1] : i_weights.lin[3];

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else if (en1) r1_valid <= acc;
        if (en1) begin
            r1_p0   <= PW'(s1) * PW'($signed(i_weights.quad[0]));
            r1_p1   <= PW'(s2) * PW'($signed(i_weights.quad[1]));
            r1_p2   <= PW'(s3) * PW'($signed(i_weights.quad[2]));
            r1_l0   <= PW'(la) * PW'(wa);
            r1_l1   <= PW'(lb) * PW'(wb);
            r1_min  <= smin;
            r1_max  <= smax;
            r1_err  <= err;
            r1_last <= i_item.last_point;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else if (en2) r2_valid <= r1_valid;
        if (en2) begin
            r2_qs   <= SumWidth'(r1_p0) + SumWidth'(r1_p1) + SumWidth'(r1_p2) + Half;
            r2_ls   <= SumWidth'(r1_l0) + SumWidth'(r1_l1) + Half;
            r2_min  <= r1_min;
            r2_max  <= r1_max;
            r2_err  <= r1_err;
            r2_last <= r1_last;
        end
    end

    // stage 3: round, limit check, select
    assign qd  = finish(r2_qs);
    assign ld  = finish(r2_ls);
    assign lin = (qd > r2_max) || (qd < r2_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else if (en3) r3_valid <= r2_valid;
        if (en3) begin
            r3_value <= (r2_err != ERR_OK) ? '0 : (lin ? ld : qd);
            r3_lin   <= (r2_err == ERR_OK) && lin;
            r3_err   <= r2_err;
            r3_last  <= r2_last;
        end
    end

    assign o_result.valid       = r3_valid;
    assign o_result.value       = r3_value;
    assign o_result.used_linear = r3_lin;
    assign o_result.error_code  = r3_err;
    assign o_result.last_result = r3_last;
endmodule

// File: sv/eno_limited_time_interpolator.sv
// Limited three-level time interpolator: one grid point per transaction, one
// result per transaction. Points stream at one per cycle, when the output is not
// stalled, through the product, sum and round/select stages. After reset and after
// every register write a weight sequencer forms the seven weights one at a time
// with a shared 32x32 multiplier and a bit-serial divider; until it is done no
// input transaction is accepted, while register writes are taken as usual.
// Write registers only when no transaction is in flight.
module eno_limited_time_interpolator
    import eli_pkg::*;
#(
    parameter int SAMPLE_WIDTH         = 32,
    parameter int WEIGHT_FRACTION_BITS = 28
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    eli_in_if.sink               i_item,
    eli_out_if.source            o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    t_times   times;
    t_weights weights;
    logic     wr;

    // configuration registers
    eli_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_times (times),
        .o_wr    (wr)
    );

    // weight formation
    eli_weight_unit #(
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_weights (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_times   (times),
        .i_wr      (wr),
        .o_weights (weights)
    );

    // per-point blend pipeline
    eli_blend_pipe #(
        .SAMPLE_WIDTH         (SAMPLE_WIDTH),
        .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
    ) u_pipe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_times   (times),
        .i_weights (weights),
        .i_item    (i_item),
        .o_result  (o_result)
    );
endmodule
